>>> hdl/triggered_block_sender_stop_and_wait_assert.svh
// Assertion macros shared by the triggered block sender modules.
`ifndef TRIGGERED_BLOCK_SENDER_STOP_AND_WAIT_ASSERT_SVH
`define TRIGGERED_BLOCK_SENDER_STOP_AND_WAIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define TBSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define TBSS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TBSS_ASSERT(lbl, prop, msg)
`define TBSS_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/tbss_pkg.sv
// Types, constants and the CRC step function of the triggered block sender.
package tbss_pkg;

	localparam int unsigned IdW = 29;
	localparam int unsigned IdxW = 4;
	localparam int unsigned ByteW = 8;
	localparam int unsigned PayW = 40;
	localparam int unsigned CrcW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 29;

	localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
	localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

	localparam logic [IdW-1:0] TriggerIdRst = 29'h01200333;
	localparam logic [IdW-1:0] StartIdRst = 29'h01210333;
	localparam logic [IdW-1:0] AckBaseIdRst = 29'h01290333;
	localparam logic [IdxW-1:0] FrameCountRst = 4'd12;
	localparam logic [ByteW-1:0] DataBaseRst = 8'h10;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_TRIG_ID = 3'd0,
		CFG_TX_BASE_ID = 3'd1,
		CFG_ACK_BASE = 3'd2,
		CFG_NUM_FRAMES = 3'd3,
		CFG_DATA_BASE = 3'd4
	} cfg_idx_t;

	// Configuration register contents.
	typedef struct packed {
		logic [IdW-1:0] trig_id;
		logic [IdW-1:0] tx_base_id;
		logic [IdW-1:0] ack_base;
		logic [IdxW-1:0] num_frames;
		logic [ByteW-1:0] data_base;
	} cfg_t;

	// Frame request from the control stage to the result stage.
	typedef struct packed {
		logic valid;
		logic [IdxW-1:0] k;
		logic last;
	} emit_t;

	// Times five of a frame index, used for identifiers and pattern bytes.
	function automatic logic [6:0] times5(input logic [IdxW-1:0] k);
		return {3'b000, k} + {1'b0, k, 2'b00};
	endfunction

	// One byte of Modbus CRC-16, reflected polynomial, LSB first.
	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] data);
		logic [CrcW-1:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/triggered_block_sender_stop_and_wait.sv
// Top level of the triggered block sender with stop-and-wait acks.
//
//   Channel  Direction  Handshake           Payload
//   rx       in         in_valid/in_stall   rx_id, rx_extended
//   tx       out        out_valid/out_stall tx_id, frame_number, payload,
//                                           check_value, is_last
//   cfg      in         cfg_we              cfg_index, cfg_data
//
// One received frame is accepted per cycle while the input is not stalled. A data
// frame passes through the input register, then the decision, pattern and
// six-byte CRC settle into the result register.
// Reset clears the transfer state and both valid flags; no clearing pass.
// A stalled output holds the result register, and the input stalls only while
// an item sits in the input register and the result register is full and stalled.
module triggered_block_sender_stop_and_wait #(
	parameter int unsigned MAX_FRAMES = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [tbss_pkg::IdW-1:0] rx_id,
	input  logic rx_extended,
	output logic out_valid,
	input  logic out_stall,
	output logic [tbss_pkg::IdW-1:0] tx_id,
	output logic [tbss_pkg::IdxW-1:0] frame_number,
	output logic [tbss_pkg::PayW-1:0] payload,
	output logic [tbss_pkg::CrcW-1:0] check_value,
	output logic is_last,
	input  logic cfg_we,
	input  logic [tbss_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [tbss_pkg::CfgDataW-1:0] cfg_data
);
	import tbss_pkg::*;

	cfg_t cfg_q;
	emit_t emit;
	logic advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_id <= TriggerIdRst;
			cfg_q.tx_base_id <= StartIdRst;
			cfg_q.ack_base <= AckBaseIdRst;
			cfg_q.num_frames <= FrameCountRst;
			cfg_q.data_base <= DataBaseRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TRIG_ID: cfg_q.trig_id <= cfg_data[IdW-1:0];
				CFG_TX_BASE_ID: cfg_q.tx_base_id <= cfg_data[IdW-1:0];
				CFG_ACK_BASE: cfg_q.ack_base <= cfg_data[IdW-1:0];
				CFG_NUM_FRAMES: cfg_q.num_frames <= cfg_data[IdxW-1:0];
				CFG_DATA_BASE: cfg_q.data_base <= cfg_data[ByteW-1:0];
				default: begin
				end
			endcase
		end
	end

	tbss_ctrl #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_id(rx_id),
		.rx_extended(rx_extended),
		.cfg(cfg_q),
		.advance(advance),
		.emit(emit)
	);

	tbss_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.emit(emit),
		.cfg(cfg_q),
		.advance(advance),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_id(tx_id),
		.frame_number(frame_number),
		.payload(payload),
		.check_value(check_value),
		.is_last(is_last)
	);

endmodule

>>> hdl/tbss_ctrl.sv
// Input register, transfer state and the trigger/ack decision.
module tbss_ctrl #(
	parameter int unsigned MAX_FRAMES = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [tbss_pkg::IdW-1:0] rx_id,
	input  logic rx_extended,
	input  tbss_pkg::cfg_t cfg,
	input  logic advance,
	output tbss_pkg::emit_t emit
);
	import tbss_pkg::*;
	`include "triggered_block_sender_stop_and_wait_assert.svh"

	localparam logic [IdxW-1:0] MaxFrames = IdxW'(MAX_FRAMES);

	logic valid_s1;
	logic [IdW-1:0] id_s1;
	logic ext_s1;
	logic waiting_q;
	logic [IdxW-1:0] index_q;

	logic [IdxW-1:0] eff_count;
	logic [IdW-1:0] ack_id;
	logic [IdxW:0] index_inc;
	logic [IdxW:0] next_inc;
	logic take;
	logic hit_trigger;
	logic hit_ack;

	// Input stage holds while the result register cannot take a new frame.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			id_s1 <= rx_id;
			ext_s1 <= rx_extended;
		end
	end

	// Effective frame count, clamped to the supported range.
	always_comb begin
		if (cfg.num_frames == '0) begin
			eff_count = IdxW'(1);
		end else if (cfg.num_frames > MaxFrames) begin
			eff_count = MaxFrames;
		end else begin
			eff_count = cfg.num_frames;
		end
	end

	// Match the stored item against the trigger or the expected ack.
	assign ack_id = cfg.ack_base + IdW'(times5(index_q));
	assign index_inc = {1'b0, index_q} + (IdxW+1)'(1);
	assign take = valid_s1 && advance && ext_s1;
	assign hit_trigger = take && !waiting_q && (id_s1 == cfg.trig_id);
	assign hit_ack = take && waiting_q && (id_s1 == ack_id);

	always_comb begin
		emit.valid = 1'b0;
		emit.k = '0;
		if (hit_trigger) begin
			emit.valid = 1'b1;
		end else if (hit_ack && (index_inc < {1'b0, eff_count})) begin
			emit.valid = 1'b1;
			emit.k = index_inc[IdxW-1:0];
		end
		next_inc = {1'b0, emit.k} + (IdxW+1)'(1);
		emit.last = (next_inc >= {1'b0, eff_count});
	end

	// Transfer state: waiting for an ack and the index of the pending frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			index_q <= '0;
		end else if (hit_trigger) begin
			waiting_q <= 1'b1;
			index_q <= '0;
		end else if (hit_ack) begin
			if (index_inc < {1'b0, eff_count}) begin
				index_q <= index_inc[IdxW-1:0];
			end else begin
				waiting_q <= 1'b0;
				index_q <= '0;
			end
		end
	end

	`TBSS_ASSERT(a_emit_needs_item, emit.valid |-> (valid_s1 && advance), "emit without item")
	`TBSS_NEVER(a_idle_index_zero, !waiting_q && index_q != '0, "index set while idle")
	`TBSS_ASSERT(a_ack_next_frame, (emit.valid && waiting_q) |-> (emit.k == index_inc[IdxW-1:0]),
		"ack did not request the next frame")

endmodule

>>> hdl/tbss_out.sv
// Frame field generation, CRC and the result register.
module tbss_out (
	input  logic clk,
	input  logic arst_n,
	input  tbss_pkg::emit_t emit,
	input  tbss_pkg::cfg_t cfg,
	output logic advance,
	output logic out_valid,
	input  logic out_stall,
	output logic [tbss_pkg::IdW-1:0] tx_id,
	output logic [tbss_pkg::IdxW-1:0] frame_number,
	output logic [tbss_pkg::PayW-1:0] payload,
	output logic [tbss_pkg::CrcW-1:0] check_value,
	output logic is_last
);
	import tbss_pkg::*;
	`include "triggered_block_sender_stop_and_wait_assert.svh"

	logic out_valid_q;
	logic [IdW-1:0] tx_id_q;
	logic [IdxW-1:0] frame_number_q;
	logic [PayW-1:0] payload_q;
	logic [CrcW-1:0] check_value_q;
	logic is_last_q;

	logic [6:0] k5;
	logic [ByteW-1:0] pat0;
	logic [ByteW-1:0] pat [5];
	logic [IdxW-1:0] number;
	logic [PayW-1:0] pay;
	logic [CrcW-1:0] crc;

	// The result register takes a new frame when empty or being drained.
	assign advance = !out_valid_q || !out_stall;

	// Identifier, frame number, pattern bytes and CRC of the requested frame.
	assign k5 = times5(emit.k);
	assign pat0 = cfg.data_base + {1'b0, k5};
	assign number = emit.k + IdxW'(1);

	always_comb begin
		crc = crc_byte(CrcInit, {4'h0, number});
		for (int j = 0; j < 5; j++) begin
			pat[j] = pat0 + ByteW'(j);
			crc = crc_byte(crc, pat[j]);
		end
		pay = {pat[0], pat[1], pat[2], pat[3], pat[4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit.valid) begin
			tx_id_q <= cfg.tx_base_id + IdW'(k5);
			frame_number_q <= number;
			payload_q <= pay;
			check_value_q <= crc;
			is_last_q <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_id = tx_id_q;
	assign frame_number = frame_number_q;
	assign payload = payload_q;
	assign check_value = check_value_q;
	assign is_last = is_last_q;

	`TBSS_NEVER(a_emit_blocked, emit.valid && !advance, "frame requested while output is full")
	`TBSS_ASSERT(a_load_number, (emit.valid && advance) |=>
		(out_valid_q && frame_number_q == $past(number)), "frame not loaded")
	`TBSS_NEVER(a_number_nonzero, out_valid_q && frame_number_q == '0, "frame number zero")

endmodule
